// ===== design/aes_pkg.sv =====
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } aes_out_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } aes_cfg_t;

    typedef enum logic [2:0] {
        REG_KEY_SIZE  = 3'd0,
        REG_KEY_WORD0 = 3'd1,
        REG_KEY_WORD1 = 3'd2,
        REG_KEY_WORD2 = 3'd3,
        REG_KEY_WORD3 = 3'd4
    } aes_reg_t;

    localparam logic [1:0] KEY_SIZE_192 = 2'd1;
    localparam logic [1:0] KEY_SIZE_256 = 2'd2;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== design/aes_key_sched.sv =====
module aes_key_sched (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         step,
    input  logic [1:0]   key_size,
    input  logic [255:0] key,
    output logic [127:0] round_key
);
    import aes_pkg::*;

    logic [31:0] w_reg [8];
    logic [31:0] w_next [8];
    logic [7:0]  rcon_reg;
    logic [7:0]  rcon_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [2:0]  last_phase;
    logic        is_192;
    logic        is_256;

    assign is_192 = (key_size == KEY_SIZE_192);
    assign is_256 = (key_size == KEY_SIZE_256);
    assign last_phase = is_192 ? 3'd5 : (is_256 ? 3'd7 : 3'd3);

    // The schedule keeps a window of the next nk words; each step emits the oldest
    // word and appends one new word, so the words leave in schedule order.
    always_comb
    begin
        logic [31:0] t;
        logic [31:0] prev;
        logic [31:0] base;
        prev = w_reg[last_phase];
        base = w_reg[0];
        t = prev;
        rcon_next = rcon_reg;
        if (phase_reg == 3'd0)
        begin
            t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
            rcon_next = xtime(rcon_reg);
        end
        else if (is_256 && phase_reg == 3'd4)
        begin
            t = sub_word(prev);
        end
        for (int i = 0; i < 8; i++)
        begin
            w_next[i] = w_reg[i];
        end
        for (int i = 0; i < 7; i++)
        begin
            if (3'(i) < last_phase)
            begin
                w_next[i] = w_reg[i + 1];
            end
        end
        w_next[last_phase] = base ^ t;
        phase_next = (phase_reg == last_phase) ? 3'd0 : phase_reg + 3'd1;
    end

    // The last three emitted words plus the word emitted now form a round key.
    logic [31:0] q_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg  <= 8'h01;
            phase_reg <= 3'd0;
        end
        else if (start)
        begin
            rcon_reg  <= 8'h01;
            phase_reg <= 3'd0;
        end
        else if (step)
        begin
            rcon_reg  <= rcon_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                w_reg[i] <= key[255 - 32 * i -: 32];
            end
        end
        else if (step)
        begin
            for (int i = 0; i < 8; i++)
            begin
                w_reg[i] <= w_next[i];
            end
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
            q_reg[2] <= w_reg[0];
        end
    end

    assign round_key = {q_reg[0], q_reg[1], q_reg[2], w_reg[0]};

endmodule

// ===== design/aes_round.sv =====
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         final_round,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[c * 4 + r] = SBOX[s[((c + r) % 4) * 4 + r]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[c*4]   = xtime(t[c*4]) ^ xtime(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+1] = t[c*4] ^ xtime(t[c*4+1]) ^ xtime(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+2] = t[c*4] ^ t[c*4+1] ^ xtime(t[c*4+2]) ^ xtime(t[c*4+3]) ^ t[c*4+3];
            m[c*4+3] = xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ xtime(t[c*4+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            state_out[127 - 8 * i -: 8] = (final_round ? t[i] : m[i]) ^ round_key[127 - 8 * i -: 8];
        end
    end

endmodule

// ===== design/aes_block_encrypt.sv =====
// AES encryption of one 128-bit block with a 128, 192 or 256 bit key.
// Configuration beats on cfg write key_size (index 0) and key_word0..3 (1..4);
// write them only while the block is idle.
// An input beat on in carries plain_high and plain_low; one output beat on out
// carries cipher_high and cipher_low.
// After an input beat the key schedule produces round-key words one per cycle,
// four per round, and one shared round unit runs once per group of four words.
// Nr is 10, 12 or 14 rounds for a 128, 192 or 256 bit key; the rounds are paced
// by the key schedule.
// One item is processed at a time; in_ready is low while busy or while a result
// waits, so a new input beat is taken only after the last result is taken.
// When the receiver stalls, the result holds on out until taken.
// Reset clears the key registers to zero and the key size to AES-128 and
// leaves the block idle.
module aes_block_encrypt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  aes_pkg::aes_cfg_t cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  aes_pkg::aes_in_t in,
    output logic             out_valid,
    input  logic             out_ready,
    output aes_pkg::aes_out_t out
);
    import aes_pkg::*;

    typedef enum logic [1:0] {IDLE, BUSY, DONE} state_t;

    state_t       state_reg;
    logic [1:0]   key_size_reg;
    logic [255:0] key_reg;
    logic [127:0] data_reg;
    logic [127:0] round_out;
    logic [127:0] round_key;
    logic [3:0]   round_reg;
    logic [1:0]   sub_reg;
    logic [3:0]   nr;
    logic         start;
    logic         step;
    logic         fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == IDLE);
    assign out_valid = (state_reg == DONE);
    assign out       = data_reg;
    assign start     = in_valid && in_ready;
    assign step      = (state_reg == BUSY);
    assign nr = (key_size_reg == KEY_SIZE_192) ? 4'd12 :
                ((key_size_reg == KEY_SIZE_256) ? 4'd14 : 4'd10);

    // Round key r is complete when sub_reg is 3 in its group; round 0 is added at start.
    assign fire = step && (sub_reg == 2'd3) && (round_reg != 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= 2'd0;
            key_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg.index)
                REG_KEY_SIZE:  key_size_reg <= cfg.data[1:0];
                REG_KEY_WORD0: key_reg[255:192] <= cfg.data;
                REG_KEY_WORD1: key_reg[191:128] <= cfg.data;
                REG_KEY_WORD2: key_reg[127:64]  <= cfg.data;
                REG_KEY_WORD3: key_reg[63:0]    <= cfg.data;
                default: ;
            endcase
        end
    end

    aes_key_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .step      (step),
        .key_size  (key_size_reg),
        .key       (key_reg),
        .round_key (round_key)
    );

    aes_round u_round (
        .state_in    (data_reg),
        .round_key   (round_key),
        .final_round (round_reg == nr),
        .state_out   (round_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            round_reg <= 4'd0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= BUSY;
                        round_reg <= 4'd0;
                        sub_reg   <= 2'd0;
                    end
                end
                BUSY:
                begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                    begin
                        round_reg <= round_reg + 4'd1;
                        if (round_reg == nr)
                        begin
                            state_reg <= DONE;
                        end
                    end
                end
                DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg <= {in.plain_high, in.plain_low} ^ key_reg[255:128];
        end
        else if (fire)
        begin
            data_reg <= round_out;
        end
    end

endmodule

// ===== design/aes_block_encrypt_checker.sv =====
module aes_block_encrypt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input aes_pkg::aes_out_t out
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out))
        else $error("Stalled output beat changed.");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input taken while a result waits.");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("Result appeared too early.");
endmodule

bind aes_block_encrypt aes_block_encrypt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out       (out)
);
